// ===== sv/cusp_pkg.sv =====
// Shared types, constants and helpers for the chroma upsampling YUV to RGB block.
// No dependencies; used by every module of the block.
`default_nettype none

package cusp_pkg;

  localparam int unsigned WIDTH_W = 15;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned IDX_W   = 14;
  localparam int unsigned FRAC_W  = 6;

  localparam logic [15:0] CoefY  = 16'd19077;
  localparam logic [15:0] CoefVr = 16'd26149;
  localparam logic [15:0] CoefUg = 16'd6419;
  localparam logic [15:0] CoefVg = 16'd13320;
  localparam logic [15:0] CoefUb = 16'd33050;
  localparam logic [17:0] OffR   = 18'd14234;
  localparam logic [17:0] OffG   = 18'd8708;
  localparam logic [17:0] OffB   = 18'd17685;
  localparam logic signed [17:0] ClipTop = 18'sd16383;  // (256 << 6) - 1

  typedef struct packed {
    logic [PIX_W-1:0] upper_u;
    logic [PIX_W-1:0] upper_v;
    logic [PIX_W-1:0] lower_u;
    logic [PIX_W-1:0] lower_v;
    logic [PIX_W-1:0] luma_top_even;
    logic [PIX_W-1:0] luma_top_odd;
    logic [PIX_W-1:0] luma_bottom_even;
    logic [PIX_W-1:0] luma_bottom_odd;
    logic             has_bottom;
  } cusp_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             is_bottom;
    logic [IDX_W-1:0] pixel_index;
    logic             last;
  } cusp_out_t;

  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
    logic             is_bottom;
    logic [IDX_W-1:0] pixel_index;
    logic             last;
  } cusp_job_t;

  typedef enum logic [1:0] {
    PIX_EDGE,
    PIX_ODD,
    PIX_EVEN,
    PIX_TAIL
  } cusp_pix_e;

  function automatic logic [PIX_W-1:0] clip8(input logic signed [17:0] val);
    logic [PIX_W-1:0] res;
    if (val < 18'sd0) begin
      res = '0;
    end else if (val > ClipTop) begin
      res = 8'hFF;
    end else begin
      res = val[FRAC_W+PIX_W-1:FRAC_W];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cusp_front.sv =====
// Front end: accepts column words, keeps previous-column state and issues one
// pixel job (luma, upsampled chroma, position) per unstalled cycle. Uses cusp_pkg.
`default_nettype none

module cusp_front #(
  parameter int unsigned MAX_WIDTH = 16384
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  cusp_pkg::cusp_in_t           in_data_i,
  input  wire                          cfg_we_i,
  input  wire [cusp_pkg::WIDTH_W-1:0]  cfg_wdata_i,
  output logic                         job_valid_o,
  input  wire                          job_ready_i,
  output cusp_pkg::cusp_job_t          job_data_o
);

  localparam int unsigned CNT_W = (MAX_WIDTH > 2) ? $clog2((MAX_WIDTH + 1) / 2) : 1;
  localparam logic [cusp_pkg::WIDTH_W-1:0] WMax =
      (MAX_WIDTH < 32767) ? cusp_pkg::WIDTH_W'(MAX_WIDTH) : '1;

  // width register, decoded
  logic [CNT_W-1:0] last_col_q, last_col_d;
  logic             even_q, even_d;
  logic [cusp_pkg::WIDTH_W-1:0] w_eff, w_m1;

  // running state
  logic [CNT_W-1:0] col_q, col_d;
  logic [7:0] prev_uu_q, prev_uv_q, prev_lu_q, prev_lv_q, prev_yt_q, prev_yb_q;

  // word being issued
  cusp_pkg::cusp_in_t item_q;
  logic [7:0] pu_u_q, pu_v_q, pl_u_q, pl_v_q, py_t_q, py_b_q;
  logic [CNT_W-1:0] x_q;
  logic tail_q;
  logic busy_q, busy_d;
  logic row_q, row_d;
  logic [1:0] sub_q, sub_d;

  logic accept, push, row_end, job_last, x_zero, is_final;
  cusp_pkg::cusp_pix_e kind;

  always_comb begin
    w_eff = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      w_eff = cusp_pkg::WIDTH_W'(1);
    end else if (cfg_wdata_i > WMax) begin
      w_eff = WMax;
    end
    w_m1       = w_eff - cusp_pkg::WIDTH_W'(1);
    last_col_d = CNT_W'(w_m1[cusp_pkg::WIDTH_W-1:1]);
    even_d     = ~w_eff[0];
  end

  assign is_final = (col_q >= last_col_q);
  assign x_zero   = (x_q == '0);

  always_comb begin
    if (x_zero) begin
      kind = (sub_q == 2'd0) ? cusp_pkg::PIX_EDGE : cusp_pkg::PIX_TAIL;
    end else begin
      case (sub_q)
        2'd0:    kind = cusp_pkg::PIX_ODD;
        2'd1:    kind = cusp_pkg::PIX_EVEN;
        default: kind = cusp_pkg::PIX_TAIL;
      endcase
    end
    if (x_zero) begin
      row_end = tail_q ? (sub_q == 2'd1) : (sub_q == 2'd0);
    end else begin
      row_end = tail_q ? (sub_q == 2'd2) : (sub_q == 2'd1);
    end
    job_last = row_end && (row_q || !item_q.has_bottom);
  end

  assign job_valid_o = busy_q;
  assign push        = busy_q && job_ready_i;
  assign in_ready_o  = !busy_q || (push && job_last);
  assign accept      = in_valid_i && in_ready_o;

  // chroma upsampling for the current row
  logic [7:0]  t_u, t_v, c_u, c_v, a_u, a_v, o_u, o_v, ye, yo, py;
  logic [10:0] au, av;
  logic [11:0] s12u, s12v, s03u, s03v;
  logic [8:0]  d12u, d12v, d03u, d03v, m0u, m0v, m1u, m1v;
  logic [7:0]  b0u, b0v, b1u, b1v;
  logic [9:0]  su0, sv0, su1, sv1, eus, evs;
  logic [7:0]  u0, v0, u1, v1, eu, ev;
  logic [CNT_W:0] twox;

  always_comb begin
    t_u = item_q.upper_u;
    t_v = item_q.upper_v;
    c_u = item_q.lower_u;
    c_v = item_q.lower_v;
    a_u = row_q ? c_u : t_u;
    a_v = row_q ? c_v : t_v;
    o_u = row_q ? t_u : c_u;
    o_v = row_q ? t_v : c_v;
    ye  = row_q ? item_q.luma_bottom_even : item_q.luma_top_even;
    yo  = row_q ? item_q.luma_bottom_odd : item_q.luma_top_odd;
    py  = row_q ? py_b_q : py_t_q;

    eus = 10'(a_u) + {1'b0, a_u, 1'b0} + 10'(o_u) + 10'd2;
    evs = 10'(a_v) + {1'b0, a_v, 1'b0} + 10'(o_v) + 10'd2;
    eu  = eus[9:2];
    ev  = evs[9:2];

    au   = 11'(pu_u_q) + 11'(t_u) + 11'(pl_u_q) + 11'(c_u) + 11'd8;
    av   = 11'(pu_v_q) + 11'(t_v) + 11'(pl_v_q) + 11'(c_v) + 11'd8;
    s12u = 12'(au) + ((12'(t_u) + 12'(pl_u_q)) << 1);
    s12v = 12'(av) + ((12'(t_v) + 12'(pl_v_q)) << 1);
    s03u = 12'(au) + ((12'(pu_u_q) + 12'(c_u)) << 1);
    s03v = 12'(av) + ((12'(pu_v_q) + 12'(c_v)) << 1);
    d12u = s12u[11:3];
    d12v = s12v[11:3];
    d03u = s03u[11:3];
    d03v = s03v[11:3];

    m0u = row_q ? d03u : d12u;
    m0v = row_q ? d03v : d12v;
    b0u = row_q ? pl_u_q : pu_u_q;
    b0v = row_q ? pl_v_q : pu_v_q;
    m1u = row_q ? d12u : d03u;
    m1v = row_q ? d12v : d03v;
    b1u = row_q ? c_u : t_u;
    b1v = row_q ? c_v : t_v;
    su0 = 10'(m0u) + 10'(b0u);
    sv0 = 10'(m0v) + 10'(b0v);
    su1 = 10'(m1u) + 10'(b1u);
    sv1 = 10'(m1v) + 10'(b1v);
    u0  = su0[8:1];
    v0  = sv0[8:1];
    u1  = su1[8:1];
    v1  = sv1[8:1];

    twox = {x_q, 1'b0};

    job_data_o.is_bottom = row_q;
    job_data_o.last      = job_last;
    case (kind)
      cusp_pkg::PIX_ODD: begin
        job_data_o.y           = py;
        job_data_o.u           = u0;
        job_data_o.v           = v0;
        job_data_o.pixel_index = cusp_pkg::IDX_W'(twox - 1'b1);
      end
      cusp_pkg::PIX_EVEN: begin
        job_data_o.y           = ye;
        job_data_o.u           = u1;
        job_data_o.v           = v1;
        job_data_o.pixel_index = cusp_pkg::IDX_W'(twox);
      end
      cusp_pkg::PIX_TAIL: begin
        job_data_o.y           = yo;
        job_data_o.u           = eu;
        job_data_o.v           = ev;
        job_data_o.pixel_index = cusp_pkg::IDX_W'(twox + 1'b1);
      end
      default: begin
        job_data_o.y           = ye;
        job_data_o.u           = eu;
        job_data_o.v           = ev;
        job_data_o.pixel_index = cusp_pkg::IDX_W'(twox);
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    sub_d  = sub_q;
    col_d  = col_q;
    if (accept) begin
      busy_d = 1'b1;
      row_d  = 1'b0;
      sub_d  = 2'd0;
      col_d  = is_final ? '0 : col_q + 1'b1;
    end else if (push && job_last) begin
      busy_d = 1'b0;
    end else if (push) begin
      if (row_end) begin
        row_d = 1'b1;
        sub_d = 2'd0;
      end else begin
        sub_d = sub_q + 2'd1;
      end
    end
    if (cfg_we_i) begin
      col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      row_q      <= 1'b0;
      sub_q      <= 2'd0;
      col_q      <= '0;
      last_col_q <= '0;
      even_q     <= 1'b0;
      prev_uu_q  <= '0;
      prev_uv_q  <= '0;
      prev_lu_q  <= '0;
      prev_lv_q  <= '0;
      prev_yt_q  <= '0;
      prev_yb_q  <= '0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
      sub_q  <= sub_d;
      col_q  <= col_d;
      if (cfg_we_i) begin
        last_col_q <= last_col_d;
        even_q     <= even_d;
      end
      if (accept) begin
        prev_uu_q <= in_data_i.upper_u;
        prev_uv_q <= in_data_i.upper_v;
        prev_lu_q <= in_data_i.lower_u;
        prev_lv_q <= in_data_i.lower_v;
        prev_yt_q <= in_data_i.luma_top_odd;
        prev_yb_q <= in_data_i.luma_bottom_odd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      pu_u_q <= prev_uu_q;
      pu_v_q <= prev_uv_q;
      pl_u_q <= prev_lu_q;
      pl_v_q <= prev_lv_q;
      py_t_q <= prev_yt_q;
      py_b_q <= prev_yb_q;
      x_q    <= col_q;
      tail_q <= is_final && even_q;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cusp_fifo.sv =====
// Short job queue between the front end and the color converter.
// Depends on cusp_pkg for the job word type.
`default_nettype none

module cusp_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_valid_i,
  output logic                 push_ready_o,
  input  cusp_pkg::cusp_job_t  push_data_i,
  output logic                 pop_valid_o,
  input  wire                  pop_ready_i,
  output cusp_pkg::cusp_job_t  pop_data_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  cusp_pkg::cusp_job_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != (PTR_W+1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cusp_back.sv =====
// Back end: fixed-point YUV to RGB conversion, product stage then sum and clip
// into the output register. Depends on cusp_pkg.
`default_nettype none

module cusp_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  job_valid_i,
  output logic                 job_ready_o,
  input  cusp_pkg::cusp_job_t  job_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output cusp_pkg::cusp_out_t  out_data_o
);

  logic adv;
  logic s1_valid_q, out_valid_q;
  logic [23:0] p_y, p_vr, p_ug, p_vg, p_ub;
  logic [14:0] yy_q, vr_q;
  logic [12:0] ug_q;
  logic [13:0] vg_q;
  logic [15:0] ub_q;
  logic        s1_bot_q, s1_last_q;
  logic [cusp_pkg::IDX_W-1:0] s1_idx_q;
  logic signed [17:0] r_s, g_s, b_s;
  cusp_pkg::cusp_out_t out_q;

  assign adv         = !out_valid_q || out_ready_i;
  assign job_ready_o = adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign p_y  = 24'(job_data_i.y) * 24'(cusp_pkg::CoefY);
  assign p_vr = 24'(job_data_i.v) * 24'(cusp_pkg::CoefVr);
  assign p_ug = 24'(job_data_i.u) * 24'(cusp_pkg::CoefUg);
  assign p_vg = 24'(job_data_i.v) * 24'(cusp_pkg::CoefVg);
  assign p_ub = 24'(job_data_i.u) * 24'(cusp_pkg::CoefUb);

  assign r_s = 18'(yy_q) + 18'(vr_q) - cusp_pkg::OffR;
  assign g_s = 18'(yy_q) - 18'(ug_q) - 18'(vg_q) + cusp_pkg::OffG;
  assign b_s = 18'(yy_q) + 18'(ub_q) - cusp_pkg::OffB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= job_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yy_q      <= p_y[22:8];
      vr_q      <= p_vr[22:8];
      ug_q      <= p_ug[20:8];
      vg_q      <= p_vg[21:8];
      ub_q      <= p_ub[23:8];
      s1_bot_q  <= job_data_i.is_bottom;
      s1_idx_q  <= job_data_i.pixel_index;
      s1_last_q <= job_data_i.last;
      out_q.red         <= cusp_pkg::clip8(r_s);
      out_q.green       <= cusp_pkg::clip8(g_s);
      out_q.blue        <= cusp_pkg::clip8(b_s);
      out_q.is_bottom   <= s1_bot_q;
      out_q.pixel_index <= s1_idx_q;
      out_q.last        <= s1_last_q;
    end
  end

endmodule

`default_nettype wire

// ===== sv/chroma_upsample_yuv_to_rgb.sv =====
// Top level of the 4:2:0 chroma upsampling YUV to RGB converter.
// Depends on cusp_pkg, cusp_front, cusp_fifo and cusp_back.
//
// Each input word is one chroma column of a line pair and yields one to three
// RGB pixels per row (up to six), top row first, one pixel per cycle on the
// output when nothing stalls. An input word holds the front end until its
// last pixel job is issued; it has 1 to 6 pixels, 4 for an interior column
// with a bottom row. The front end issues one pixel job per cycle, while the
// 4-entry queue has room; the back end converts one pixel per cycle, while
// its output is not stalled, through two registered stages (product, then
// output register). Writing image_width restarts the line pair at column 0.
`default_nettype none

module chroma_upsample_yuv_to_rgb #(
  parameter int unsigned MAX_WIDTH = 16384
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  cusp_pkg::cusp_in_t           in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output cusp_pkg::cusp_out_t          out_data_o,
  input  wire                          cfg_we_i,
  input  wire [cusp_pkg::WIDTH_W-1:0]  cfg_wdata_i
);

  logic                fj_valid, fj_ready, bj_valid, bj_ready;
  cusp_pkg::cusp_job_t fj_data, bj_data;

  cusp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_data_o  (fj_data)
  );

  cusp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj_data),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_data_o   (bj_data)
  );

  cusp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_data_i  (bj_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sv/cusp_checker.sv =====
// Port-level checker for chroma_upsample_yuv_to_rgb, attached by bind.
// Depends on cusp_pkg.
`default_nettype none

module cusp_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_ready_o,
  input wire                          out_valid_o,
  input wire                          out_ready_i,
  input cusp_pkg::cusp_out_t          out_data_o
);

  logic in_fire, out_fire;
  logic [3:0] pending_q;
  logic prev_last_q, prev_bot_q;
  logic [cusp_pkg::IDX_W-1:0] prev_idx_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      prev_last_q <= 1'b1;
      prev_bot_q  <= 1'b0;
      prev_idx_q  <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_fire) - 4'(out_fire && out_data_o.last);
      if (out_fire) begin
        prev_last_q <= out_data_o.last;
        prev_bot_q  <= out_data_o.is_bottom;
        prev_idx_q  <= out_data_o.pixel_index;
      end
    end
  end

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // no output without an accepted column word still owing pixels
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0 || (pending_q == '0 && 1'b0))
    else $error("output word without pending input");

  // pixels of one row come in ascending positions
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !prev_last_q && (out_data_o.is_bottom == prev_bot_q)
      |-> out_data_o.pixel_index == prev_idx_q + 1'b1)
    else $error("pixel position skipped within a row");

  // the bottom row never goes back to the top row within one word
  a_bot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !prev_last_q && prev_bot_q |-> out_data_o.is_bottom)
    else $error("top row pixel after bottom row pixel");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind chroma_upsample_yuv_to_rgb cusp_checker u_cusp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
